### rtl/lpg_pkg.sv
package lpg_pkg;

  localparam int COORD_W     = 5;
  localparam int ERR_W       = COORD_W + 3;
  localparam int CANVAS_DEF  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  typedef logic [COORD_W-1:0] coord_t;

  // one line as seen by the stepper
  typedef struct packed {
    coord_t x;     // first x (vertical: the fixed x)
    coord_t y;     // first y (vertical: lower y)
    coord_t lim;   // x end (vertical: upper y, excluded)
    coord_t dx;
    coord_t ady;
    logic   neg;   // y steps downward
    logic   vert;
  } line_cmd_t;

  function automatic coord_t clamp_coord(input coord_t v, input coord_t vmax);
    clamp_coord = (v > vmax) ? vmax : v;
  endfunction

endpackage

### rtl/lpg_front.sv
module lpg_front #(
  parameter int CANVAS_SIZE = lpg_pkg::CANVAS_DEF
) (
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [lpg_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                     q_full,
  output logic                     q_push,
  output lpg_pkg::line_cmd_t       q_cmd
);

  localparam lpg_pkg::coord_t CMAX = lpg_pkg::COORD_W'(CANVAS_SIZE - 1);

  lpg_pkg::coord_t x0, y0, x1, y1;
  lpg_pkg::coord_t ax, ay, bx, by;
  logic            swap, vert, empty;

  always_comb begin
    x0 = lpg_pkg::clamp_coord(in_tdata[4:0], CMAX);
    y0 = lpg_pkg::clamp_coord(in_tdata[9:5], CMAX);
    x1 = lpg_pkg::clamp_coord(in_tdata[14:10], CMAX);
    y1 = lpg_pkg::clamp_coord(in_tdata[19:15], CMAX);
    swap = x0 > x1;
    ax = swap ? x1 : x0;
    ay = swap ? y1 : y0;
    bx = swap ? x0 : x1;
    by = swap ? y0 : y1;
    vert  = (ax == bx);
    empty = vert && (ay == by);

    q_cmd.x    = ax;
    q_cmd.dx   = bx - ax;
    q_cmd.neg  = by < ay;
    q_cmd.ady  = (by < ay) ? (ay - by) : (by - ay);
    q_cmd.vert = vert;
    if (vert) begin
      q_cmd.y   = (ay < by) ? ay : by;
      q_cmd.lim = (ay < by) ? by : ay;
    end else begin
      q_cmd.y   = ay;
      q_cmd.lim = bx;
    end
  end

  // lines with equal endpoints are taken and dropped here
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && !empty;

endmodule

### rtl/lpg_queue.sv
module lpg_queue #(
  parameter int DEPTH = lpg_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lpg_pkg::line_cmd_t push_cmd,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output lpg_pkg::line_cmd_t pop_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lpg_pkg::line_cmd_t mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_cmd = mem_r[rptr_r];

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wptr_nxt = push ? ptr_inc(wptr_r) : wptr_r;
    rptr_nxt = pop ? ptr_inc(rptr_r) : rptr_r;
    cnt_nxt  = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/lpg_back.sv
module lpg_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  lpg_pkg::line_cmd_t q_cmd,
  output logic               q_pop,
  output logic               busy,
  output logic               out_tvalid,
  input  logic               out_tready,
  output lpg_pkg::coord_t    pixel_x,
  output lpg_pkg::coord_t    pixel_y,
  output logic               last_pixel
);

  localparam int CW = lpg_pkg::COORD_W;
  localparam int EW = lpg_pkg::ERR_W;

  logic busy_r, busy_nxt, ovalid_r, ovalid_nxt, phb_r, phb_nxt;
  lpg_pkg::coord_t x_r, x_nxt, y_r, y_nxt, lim_r, lim_nxt, dx_r, dx_nxt, ady_r, ady_nxt;
  lpg_pkg::coord_t px_r, px_nxt, py_r, py_nxt;
  logic neg_r, neg_nxt, vert_r, vert_nxt, last_r, last_nxt;
  logic signed [EW-1:0] err_r, err_nxt, sum, dx_s, two_ady, two_dx;
  lpg_pkg::coord_t x_inc, y_inc, y_step;
  logic load, emit, more, done;

  always_comb begin
    load    = !busy_r && q_valid;
    emit    = busy_r && (!ovalid_r || out_tready);
    dx_s    = $signed({{(EW-CW){1'b0}}, dx_r});
    two_dx  = $signed({{(EW-CW-1){1'b0}}, dx_r, 1'b0});
    two_ady = $signed({{(EW-CW-1){1'b0}}, ady_r, 1'b0});
    // phase a adds the slope term, phase b steps y and pays it back
    sum     = phb_r ? (err_r - two_dx) : (err_r + two_ady);
    more    = (sum >= dx_s);
    x_inc   = x_r + 1'b1;
    y_inc   = y_r + 1'b1;
    y_step  = neg_r ? (y_r - 1'b1) : y_inc;
    done    = vert_r ? (y_inc == lim_r) : (!more && (x_inc == lim_r));

    busy_nxt   = busy_r;
    ovalid_nxt = ovalid_r && !out_tready;
    phb_nxt    = phb_r;
    x_nxt = x_r;  y_nxt = y_r;  lim_nxt = lim_r;  dx_nxt = dx_r;  ady_nxt = ady_r;
    neg_nxt = neg_r;  vert_nxt = vert_r;  err_nxt = err_r;
    px_nxt = px_r;  py_nxt = py_r;  last_nxt = last_r;

    if (load) begin
      busy_nxt = 1'b1;
      phb_nxt  = 1'b0;
      x_nxt    = q_cmd.x;
      y_nxt    = q_cmd.y;
      lim_nxt  = q_cmd.lim;
      dx_nxt   = q_cmd.dx;
      ady_nxt  = q_cmd.ady;
      neg_nxt  = q_cmd.neg;
      vert_nxt = q_cmd.vert;
      err_nxt  = '0;
    end

    if (emit) begin
      ovalid_nxt = 1'b1;
      px_nxt     = x_r;
      py_nxt     = y_r;
      last_nxt   = done;
      if (done) begin
        busy_nxt = 1'b0;
      end
      if (vert_r) begin
        y_nxt = y_inc;
      end else begin
        err_nxt = sum;
        if (phb_r) begin
          y_nxt = y_step;
        end
        phb_nxt = more;
        if (!more) begin
          x_nxt = x_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      phb_r    <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      phb_r    <= phb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    lim_r  <= lim_nxt;
    dx_r   <= dx_nxt;
    ady_r  <= ady_nxt;
    neg_r  <= neg_nxt;
    vert_r <= vert_nxt;
    err_r  <= err_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    last_r <= last_nxt;
  end

  assign q_pop      = load;
  assign busy       = busy_r;
  assign out_tvalid = ovalid_r;
  assign pixel_x    = px_r;
  assign pixel_y    = py_r;
  assign last_pixel = last_r;

endmodule

### rtl/line_pixel_generator_top.sv
// out_tvalid for the first pixel of a line rises once its beat has been written into the line queue,
// loaded into the stepper and first emitted
// the stepper emits one pixel per cycle while out_tready allows it, once the line is loaded
// into the stepper; the two-entry line queue lets the next lines be accepted meanwhile
// lines with equal endpoints are accepted and produce no beat
// reset (rst_n low, synchronous) empties the queue and the stepper and drops out_tvalid
module line_pixel_generator_top #(
  parameter int CANVAS_SIZE = lpg_pkg::CANVAS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lpg_pkg::IN_TDATA_W-1:0]  in_tdata,  // start_x, start_y, end_x, end_y, pad
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lpg_pkg::OUT_TDATA_W-1:0] out_tdata, // pixel_x, pixel_y, pad
  output logic                          out_tlast
);

  lpg_pkg::line_cmd_t push_cmd, pop_cmd;
  lpg_pkg::coord_t    px, py;
  logic q_push, q_full, q_pop, q_valid, busy;

  lpg_front #(.CANVAS_SIZE(CANVAS_SIZE)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  lpg_queue #(.DEPTH(lpg_pkg::QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  lpg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .busy       (busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .pixel_x    (px),
    .pixel_y    (py),
    .last_pixel (out_tlast)
  );

  assign out_tdata = {{(lpg_pkg::OUT_TDATA_W - 2*lpg_pkg::COORD_W){1'b0}}, py, px};

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("line queue overflow");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!busy && q_valid)) else $error("line loaded while stepper busy");

  a_on_canvas: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (px <= lpg_pkg::COORD_W'(CANVAS_SIZE - 1))
                && (py <= lpg_pkg::COORD_W'(CANVAS_SIZE - 1)))
    else $error("pixel off canvas");

  a_load_follows: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> busy) else $error("stepper did not start");

endmodule
